/* rtl/core/ffsc_pkg.sv */
// ----------------------------------------------------------------------------
// ffsc_pkg
// Shared widths, side codes and saturation limits of the free-space cell unit.
// ----------------------------------------------------------------------------
package ffsc_pkg;

  localparam int DIST_W = 32;
  localparam int COST_W = 32;
  localparam int EPS_W  = 32;
  localparam int PT_W   = 48;
  // line intercepts and interval numerators stay below 2^34 in magnitude
  localparam int NUM_W  = 36;

  typedef logic [1:0] side_t;

  localparam side_t SIDE_LEFT   = 2'd0;
  localparam side_t SIDE_BOTTOM = 2'd1;
  localparam side_t SIDE_RIGHT  = 2'd2;
  localparam side_t SIDE_TOP    = 2'd3;

  localparam logic [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

endpackage

/* rtl/core/ffsc_in_if.sv */
// ----------------------------------------------------------------------------
// ffsc_in_if
// Cell description channel: corner distances, edge costs and cell indices.
// ----------------------------------------------------------------------------
interface ffsc_in_if
  import ffsc_pkg::*;
#(
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [DIST_W-1:0]     dist_a1_b1;
  logic [DIST_W-1:0]     dist_a1_b2;
  logic [DIST_W-1:0]     dist_a2_b1;
  logic [DIST_W-1:0]     dist_a2_b2;
  logic [COST_W-1:0]     edge_cost_a;
  logic [COST_W-1:0]     edge_cost_b;
  logic [INDEX_BITS-1:0] row_index;
  logic [INDEX_BITS-1:0] col_index;

  modport source (
    output valid, dist_a1_b1, dist_a1_b2, dist_a2_b1, dist_a2_b2,
           edge_cost_a, edge_cost_b, row_index, col_index,
    input  ready
  );
  modport sink (
    input  valid, dist_a1_b1, dist_a1_b2, dist_a2_b1, dist_a2_b2,
           edge_cost_a, edge_cost_b, row_index, col_index,
    output ready
  );
endinterface

/* rtl/core/ffsc_out_if.sv */
// ----------------------------------------------------------------------------
// ffsc_out_if
// Side result channel: up to two free intervals of one cell side.
// ----------------------------------------------------------------------------
interface ffsc_out_if
  import ffsc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  side_t                  side;
  logic                   first_valid;
  logic signed [PT_W-1:0] first_start;
  logic signed [PT_W-1:0] first_end;
  logic                   second_valid;
  logic signed [PT_W-1:0] second_start;
  logic signed [PT_W-1:0] second_end;
  logic                   last_side;

  modport source (
    output valid, side, first_valid, first_start, first_end,
           second_valid, second_start, second_end, last_side,
    input  ready
  );
  modport sink (
    input  valid, side, first_valid, first_start, first_end,
           second_valid, second_start, second_end, last_side,
    output ready
  );
endinterface

/* rtl/core/ffsc_cfg_if.sv */
// ----------------------------------------------------------------------------
// ffsc_cfg_if
// Configuration write channel carrying the epsilon threshold.
// ----------------------------------------------------------------------------
interface ffsc_cfg_if
  import ffsc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/frechet_free_space_cell_unit.sv */
// ----------------------------------------------------------------------------
// frechet_free_space_cell_unit
// Free-space cell of the network Frechet distance in fixed point: builds the
// four boundary lines of a cell and emits the free intervals of its sides.
// ----------------------------------------------------------------------------
// path: a cell item passes stages a to d, the divide pipeline, stage e and
//   the output stage; the long divide pipeline makes up most of that path
// throughput: one side result per cycle unless out_ch.ready stalls; the
//   side serializer sets it; a new cell enters as SIDE_TOP leaves stage a
// reset: rst_n synchronous active low clears all valid bits and epsilon to 0
module frechet_free_space_cell_unit
  import ffsc_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ffsc_cfg_if.sink   cfg_ch,
  ffsc_in_if.sink    in_ch,
  ffsc_out_if.source out_ch
);

  localparam int DW   = NUM_W - 1 + FRAC_BITS;   // dividend and quotient bits
  localparam int RW   = COST_W + 1;              // partial remainder bits
  localparam int QSW  = DW + 1;                  // signed quotient
  localparam int BW   = INDEX_BITS + FRAC_BITS + 2;
  localparam int SW0  = (QSW > BW) ? QSW : BW;
  localparam int SW   = ((SW0 > PT_W) ? SW0 : PT_W) + 1;

  typedef struct packed {
    logic                  vld;
    side_t                 side;
    logic                  last;
    logic                  two;
    logic                  lo_pos;
    logic                  hi_lt;
    logic                  lo_neg;
    logic                  hi_neg;
    logic [INDEX_BITS-1:0] base;
    logic [COST_W-1:0]     den;
  } ctl_t;

  function automatic logic [PT_W-1:0] sat_pt(input logic [SW-1:0] v);
    if (v[SW-1:PT_W-1] == {(SW-PT_W+1){v[SW-1]}}) begin
      sat_pt = v[PT_W-1:0];
    end else begin
      sat_pt = v[SW-1] ? PT_MIN : PT_MAX;
    end
  endfunction

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;

  // configuration
  logic [EPS_W-1:0] eps_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_ch.valid) begin
      eps_r <= cfg_ch.data;
    end
  end

  // stage a: line intercepts, held while the four sides are stepped through
  logic                     a_vld_r;
  side_t                    a_side_r;
  logic signed [NUM_W-1:0]  a1_r, a2_r, a3_r, a4_r;
  logic [COST_W-1:0]        p_r, q_r;
  logic [INDEX_BITS-1:0]    i_r, j_r;
  logic [COST_W-1:0]        p_fix, q_fix;
  logic signed [NUM_W-1:0]  e_x, d11_x, d12_x, d21_x, d22_x, p_x, q_x;
  logic                     in_take;

  assign in_ch.ready = en && (!a_vld_r || a_side_r == SIDE_TOP);
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    p_fix = (in_ch.edge_cost_a == '0) ? COST_W'(1) : in_ch.edge_cost_a;
    q_fix = (in_ch.edge_cost_b == '0) ? COST_W'(1) : in_ch.edge_cost_b;
    e_x   = NUM_W'(eps_r);
    d11_x = NUM_W'(in_ch.dist_a1_b1);
    d12_x = NUM_W'(in_ch.dist_a1_b2);
    d21_x = NUM_W'(in_ch.dist_a2_b1);
    d22_x = NUM_W'(in_ch.dist_a2_b2);
    p_x   = NUM_W'(p_fix);
    q_x   = NUM_W'(q_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      a_side_r <= SIDE_LEFT;
    end else if (en) begin
      if (in_take) begin
        a_vld_r  <= 1'b1;
        a_side_r <= SIDE_LEFT;
      end else if (a_vld_r) begin
        a_vld_r  <= (a_side_r != SIDE_TOP);
        a_side_r <= a_side_r + side_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a1_r <= e_x - d11_x;
      a2_r <= d21_x + p_x - e_x;
      a3_r <= d22_x + p_x + q_x - e_x;
      a4_r <= e_x - d12_x - q_x;
      p_r  <= p_fix;
      q_r  <= q_fix;
      i_r  <= in_ch.row_index;
      j_r  <= in_ch.col_index;
    end
  end

  // stage b: pick the line pair of the current side
  logic                    b_vld_r, b_last_r, b_two_r;
  side_t                   b_side_r;
  logic signed [NUM_W-1:0] b_n1_r, b_n2_r;
  logic [COST_W-1:0]       b_den_r;
  logic [INDEX_BITS-1:0]   b_base_r;
  logic                    two_c;
  logic signed [NUM_W-1:0] n1_c, n2_c, ps, qs;
  logic [COST_W-1:0]       den_c;
  logic [INDEX_BITS-1:0]   base_c;

  always_comb begin
    ps = NUM_W'(p_r);
    qs = NUM_W'(q_r);
    case (a_side_r)
      SIDE_LEFT: begin
        two_c = a1_r <= a2_r;
        n1_c = a1_r;  n2_c = a2_r;  den_c = p_r;  base_c = i_r;
      end
      SIDE_BOTTOM: begin
        two_c = (a1_r + a4_r) <= 0;
        n1_c = a1_r;  n2_c = -a4_r;  den_c = q_r;  base_c = j_r;
      end
      SIDE_RIGHT: begin
        two_c = (a3_r - a4_r) >= (qs + qs);
        n1_c = a3_r - qs;  n2_c = a4_r + qs;  den_c = p_r;  base_c = i_r;
      end
      SIDE_TOP: begin
        two_c = (a2_r + a3_r) >= (ps + ps);
        n1_c = ps - a2_r;  n2_c = a3_r - ps;  den_c = q_r;  base_c = j_r;
      end
      default: begin
        two_c = 1'b0;
        n1_c = '0;  n2_c = '0;  den_c = p_r;  base_c = i_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= a_side_r;
      b_last_r <= (a_side_r == SIDE_TOP);
      b_two_r  <= two_c;
      b_n1_r   <= n1_c;
      b_n2_r   <= n2_c;
      b_den_r  <= den_c;
      b_base_r <= base_c;
    end
  end

  // stage c: order the two numerators and test the interval bounds
  logic                    c_vld_r, c_last_r, c_two_r, c_lo_pos_r, c_hi_lt_r;
  side_t                   c_side_r;
  logic signed [NUM_W-1:0] c_lo_r, c_hi_r;
  logic [COST_W-1:0]       c_den_r;
  logic [INDEX_BITS-1:0]   c_base_r;
  logic signed [NUM_W-1:0] lo_c, hi_c, bden_s;

  always_comb begin
    bden_s = NUM_W'(b_den_r);
    lo_c   = (b_n1_r < b_n2_r) ? b_n1_r : b_n2_r;
    hi_c   = (b_n1_r < b_n2_r) ? b_n2_r : b_n1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r   <= b_side_r;
      c_last_r   <= b_last_r;
      c_two_r    <= b_two_r;
      c_lo_r     <= lo_c;
      c_hi_r     <= hi_c;
      c_lo_pos_r <= lo_c > 0;
      c_hi_lt_r  <= hi_c < bden_s;
      c_den_r    <= b_den_r;
      c_base_r   <= b_base_r;
    end
  end

  // stage d: magnitudes for the unsigned divider
  ctl_t               d_ctl_r;
  logic [NUM_W-2:0]   d_lo_mag_r, d_hi_mag_r;
  logic signed [NUM_W-1:0] lo_neg_v, hi_neg_v;

  always_comb begin
    lo_neg_v = -c_lo_r;
    hi_neg_v = -c_hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r.vld <= 1'b0;
    end else if (en) begin
      d_ctl_r.vld <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctl_r.side   <= c_side_r;
      d_ctl_r.last   <= c_last_r;
      d_ctl_r.two    <= c_two_r;
      d_ctl_r.lo_pos <= c_lo_pos_r;
      d_ctl_r.hi_lt  <= c_hi_lt_r;
      d_ctl_r.lo_neg <= c_lo_r[NUM_W-1];
      d_ctl_r.hi_neg <= c_hi_r[NUM_W-1];
      d_ctl_r.base   <= c_base_r;
      d_ctl_r.den    <= c_den_r;
      d_lo_mag_r     <= c_lo_r[NUM_W-1] ? lo_neg_v[NUM_W-2:0] : c_lo_r[NUM_W-2:0];
      d_hi_mag_r     <= c_hi_r[NUM_W-1] ? hi_neg_v[NUM_W-2:0] : c_hi_r[NUM_W-2:0];
    end
  end

  // restoring divide pipeline, one quotient bit per stage, two lanes
  ctl_t            dv_ctl_r [0:DW];
  logic [RW-1:0]   rem_lo_r [0:DW];
  logic [RW-1:0]   rem_hi_r [0:DW];
  logic [DW-1:0]   dvd_lo_r [0:DW];
  logic [DW-1:0]   dvd_hi_r [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl_r[0].vld <= 1'b0;
    end else if (en) begin
      dv_ctl_r[0].vld <= d_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctl_r[0].side   <= d_ctl_r.side;
      dv_ctl_r[0].last   <= d_ctl_r.last;
      dv_ctl_r[0].two    <= d_ctl_r.two;
      dv_ctl_r[0].lo_pos <= d_ctl_r.lo_pos;
      dv_ctl_r[0].hi_lt  <= d_ctl_r.hi_lt;
      dv_ctl_r[0].lo_neg <= d_ctl_r.lo_neg;
      dv_ctl_r[0].hi_neg <= d_ctl_r.hi_neg;
      dv_ctl_r[0].base   <= d_ctl_r.base;
      dv_ctl_r[0].den    <= d_ctl_r.den;
      rem_lo_r[0]        <= '0;
      rem_hi_r[0]        <= '0;
      dvd_lo_r[0]        <= {d_lo_mag_r, {FRAC_BITS{1'b0}}};
      dvd_hi_r[0]        <= {d_hi_mag_r, {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [RW-1:0] rs_lo, rs_hi, den_x, rem_lo_nxt, rem_hi_nxt;
    logic [DW-1:0] ds_lo, ds_hi;
    logic          ge_lo, ge_hi;

    always_comb begin
      den_x        = RW'(dv_ctl_r[k].den);
      {rs_lo, ds_lo} = {rem_lo_r[k], dvd_lo_r[k]} << 1;
      {rs_hi, ds_hi} = {rem_hi_r[k], dvd_hi_r[k]} << 1;
      ge_lo        = rs_lo >= den_x;
      ge_hi        = rs_hi >= den_x;
      rem_lo_nxt   = ge_lo ? rs_lo - den_x : rs_lo;
      rem_hi_nxt   = ge_hi ? rs_hi - den_x : rs_hi;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl_r[k+1].vld <= 1'b0;
      end else if (en) begin
        dv_ctl_r[k+1].vld <= dv_ctl_r[k].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctl_r[k+1].side   <= dv_ctl_r[k].side;
        dv_ctl_r[k+1].last   <= dv_ctl_r[k].last;
        dv_ctl_r[k+1].two    <= dv_ctl_r[k].two;
        dv_ctl_r[k+1].lo_pos <= dv_ctl_r[k].lo_pos;
        dv_ctl_r[k+1].hi_lt  <= dv_ctl_r[k].hi_lt;
        dv_ctl_r[k+1].lo_neg <= dv_ctl_r[k].lo_neg;
        dv_ctl_r[k+1].hi_neg <= dv_ctl_r[k].hi_neg;
        dv_ctl_r[k+1].base   <= dv_ctl_r[k].base;
        dv_ctl_r[k+1].den    <= dv_ctl_r[k].den;
        rem_lo_r[k+1]        <= rem_lo_nxt;
        rem_hi_r[k+1]        <= rem_hi_nxt;
        dvd_lo_r[k+1]        <= {ds_lo[DW-1:1], ge_lo};
        dvd_hi_r[k+1]        <= {ds_hi[DW-1:1], ge_hi};
      end
    end
  end

  // stage e: floor quotients and cell-edge coordinates
  logic                  e_vld_r, e_last_r, e_two_r, e_lo_pos_r, e_hi_lt_r;
  side_t                 e_side_r;
  logic signed [QSW-1:0] e_qlo_r, e_qhi_r;
  logic [BW-1:0]         e_base0_r, e_base1_r;
  logic signed [QSW-1:0] qlo_u, qhi_u, qlo_c, qhi_c;
  logic [INDEX_BITS:0]   base_inc;

  always_comb begin
    qlo_u    = QSW'(dvd_lo_r[DW]);
    qhi_u    = QSW'(dvd_hi_r[DW]);
    // negative numerator: floor needs one more step down on a remainder
    qlo_c    = dv_ctl_r[DW].lo_neg ?
               (-qlo_u - QSW'(rem_lo_r[DW] != '0)) : qlo_u;
    qhi_c    = dv_ctl_r[DW].hi_neg ?
               (-qhi_u - QSW'(rem_hi_r[DW] != '0)) : qhi_u;
    base_inc = (INDEX_BITS+1)'(dv_ctl_r[DW].base) + (INDEX_BITS+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= dv_ctl_r[DW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r   <= dv_ctl_r[DW].side;
      e_last_r   <= dv_ctl_r[DW].last;
      e_two_r    <= dv_ctl_r[DW].two;
      e_lo_pos_r <= dv_ctl_r[DW].lo_pos;
      e_hi_lt_r  <= dv_ctl_r[DW].hi_lt;
      e_qlo_r    <= qlo_c;
      e_qhi_r    <= qhi_c;
      e_base0_r  <= BW'({dv_ctl_r[DW].base, {FRAC_BITS{1'b0}}});
      e_base1_r  <= BW'({base_inc, {FRAC_BITS{1'b0}}});
    end
  end

  // output stage: endpoints, saturation and null intervals
  side_t           out_side_r;
  logic            out_last_r, out_fv_r, out_sv_r;
  logic [PT_W-1:0] out_fs_r, out_fe_r, out_ss_r, out_se_r;
  logic [SW-1:0]   b0_x, b1_x, plo_x, phi_x;
  logic [PT_W-1:0] b0_s, b1_s, plo_s, phi_s;
  logic            fv_c, sv_c;

  always_comb begin
    b0_x  = SW'(e_base0_r);
    b1_x  = SW'(e_base1_r);
    plo_x = b0_x + SW'(e_qlo_r);
    phi_x = b0_x + SW'(e_qhi_r);
    b0_s  = sat_pt(b0_x);
    b1_s  = sat_pt(b1_x);
    plo_s = sat_pt(plo_x);
    phi_s = sat_pt(phi_x);
    fv_c  = e_two_r ? e_lo_pos_r : 1'b1;
    sv_c  = e_two_r && e_hi_lt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= e_side_r;
      out_last_r <= e_last_r;
      out_fv_r   <= fv_c;
      out_fs_r   <= fv_c ? b0_s : '0;
      out_fe_r   <= !fv_c ? '0 : (e_two_r ? plo_s : b1_s);
      out_sv_r   <= sv_c;
      out_ss_r   <= sv_c ? phi_s : '0;
      out_se_r   <= sv_c ? b1_s : '0;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.side         = out_side_r;
  assign out_ch.first_valid  = out_fv_r;
  assign out_ch.first_start  = out_fs_r;
  assign out_ch.first_end    = out_fe_r;
  assign out_ch.second_valid = out_sv_r;
  assign out_ch.second_start = out_ss_r;
  assign out_ch.second_end   = out_se_r;
  assign out_ch.last_side    = out_last_r;

endmodule

/* tb/sv/tb_frechet_free_space_cell_unit.sv */
// ----------------------------------------------------------------------------
// tb_frechet_free_space_cell_unit
// Drives cell items and epsilon writes into the free-space cell unit, predicts
// the four side results of every cell and checks each one field by field.
// ----------------------------------------------------------------------------
module tb_frechet_free_space_cell_unit;
  import ffsc_pkg::*;

  localparam int IDX_W = 16;
  localparam int FRAC  = 16;
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    side_t             side;
    logic              first_valid;
    logic [PT_W-1:0]   first_start;
    logic [PT_W-1:0]   first_end;
    logic              second_valid;
    logic [PT_W-1:0]   second_start;
    logic [PT_W-1:0]   second_end;
    logic              last_side;
  } side_res_t;

  typedef struct {
    logic [31:0] d11, d12, d21, d22, p, q;
    logic [IDX_W-1:0] i, j;
  } cell_t;

  class side_scoreboard;
    side_res_t pending[$];
    logic [31:0] eps = '0;
    int errors;
    int cells;
    int checked;

    function longint fdiv(longint n, longint d);
      longint r;
      r = n / d;
      if ((n % d) != 0 && n < 0) r = r - 1;
      return r;
    endfunction

    function longint clip(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function side_res_t side_intervals(side_t sd, bit two, longint n1, longint n2,
                                       longint den, longint base);
      side_res_t r;
      longint lo, hi;
      r = '0;
      r.side = sd;
      r.last_side = (sd == SIDE_TOP);
      if (two) begin
        lo = (n1 < n2) ? n1 : n2;
        hi = (n1 < n2) ? n2 : n1;
        if (lo > 0) begin
          r.first_valid = 1'b1;
          r.first_start = PT_W'(clip(base * ONE));
          r.first_end = PT_W'(clip(base * ONE + fdiv(lo * ONE, den)));
        end
        if (hi < den) begin
          r.second_valid = 1'b1;
          r.second_start = PT_W'(clip(base * ONE + fdiv(hi * ONE, den)));
          r.second_end = PT_W'(clip((base + 1) * ONE));
        end
      end else begin
        r.first_valid = 1'b1;
        r.first_start = PT_W'(clip(base * ONE));
        r.first_end = PT_W'(clip((base + 1) * ONE));
      end
      return r;
    endfunction

    function void note_cell(cell_t c);
      longint p, q, e, a1, a2, a3, a4, bi, bj;
      p = c.p; q = c.q; e = eps;
      if (p == 0) p = 1;
      if (q == 0) q = 1;
      bi = c.i; bj = c.j;
      a1 = e - longint'(c.d11);
      a2 = longint'(c.d21) + p - e;
      a3 = longint'(c.d22) + p + q - e;
      a4 = e - longint'(c.d12) - q;
      pending.push_back(side_intervals(SIDE_LEFT, a1 <= a2, a1, a2, p, bi));
      pending.push_back(side_intervals(SIDE_BOTTOM, a1 + a4 <= 0, a1, -a4, q, bj));
      pending.push_back(side_intervals(SIDE_RIGHT, a3 - a4 >= 2 * q, a3 - q, a4 + q,
                                       p, bi));
      pending.push_back(side_intervals(SIDE_TOP, a2 + a3 >= 2 * p, p - a2, a3 - p,
                                       q, bj));
      cells++;
    endfunction

    function void check_result(side_res_t got);
      side_res_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.side != exp_r.side) begin
        $display("%0t side exp %0d got %0d", $time, exp_r.side, got.side);
        errors++;
      end
      if (got.first_valid != exp_r.first_valid) begin
        $display("%0t first_valid exp %0b got %0b", $time, exp_r.first_valid,
                 got.first_valid);
        errors++;
      end
      if (got.first_start != exp_r.first_start) begin
        $display("%0t first_start exp %h got %h", $time, exp_r.first_start,
                 got.first_start);
        errors++;
      end
      if (got.first_end != exp_r.first_end) begin
        $display("%0t first_end exp %h got %h", $time, exp_r.first_end, got.first_end);
        errors++;
      end
      if (got.second_valid != exp_r.second_valid) begin
        $display("%0t second_valid exp %0b got %0b", $time, exp_r.second_valid,
                 got.second_valid);
        errors++;
      end
      if (got.second_start != exp_r.second_start) begin
        $display("%0t second_start exp %h got %h", $time, exp_r.second_start,
                 got.second_start);
        errors++;
      end
      if (got.second_end != exp_r.second_end) begin
        $display("%0t second_end exp %h got %h", $time, exp_r.second_end,
                 got.second_end);
        errors++;
      end
      if (got.last_side != exp_r.last_side) begin
        $display("%0t last_side exp %0b got %0b", $time, exp_r.last_side,
                 got.last_side);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  ffsc_cfg_if cfg_ch ();
  ffsc_in_if #(.INDEX_BITS(IDX_W)) in_ch ();
  ffsc_out_if out_ch ();

  side_scoreboard sb = new();

  frechet_free_space_cell_unit #(.INDEX_BITS(IDX_W), .FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall, results sampled at the edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(side_res_t'{out_ch.side, out_ch.first_valid, out_ch.first_start,
                                  out_ch.first_end, out_ch.second_valid,
                                  out_ch.second_start, out_ch.second_end,
                                  out_ch.last_side});
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_eps(logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.eps = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_cell(cell_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dist_a1_b1 <= c.d11;
    in_ch.dist_a1_b2 <= c.d12;
    in_ch.dist_a2_b1 <= c.d21;
    in_ch.dist_a2_b2 <= c.d22;
    in_ch.edge_cost_a <= c.p;
    in_ch.edge_cost_b <= c.q;
    in_ch.row_index <= c.i;
    in_ch.col_index <= c.j;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_cell(c);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h0004_0000);
      3: return $urandom_range(32'h0010_0000, 32'h0001_0000);
      default: return $urandom;
    endcase
  endfunction

  // cells are mostly near epsilon so that the two-interval cases show up
  function automatic cell_t rand_cell(logic [31:0] e);
    cell_t c;
    c.p = ($urandom_range(9) == 0) ? rand_word() : $urandom_range(32'h0003_0000, 1);
    c.q = ($urandom_range(9) == 0) ? rand_word() : $urandom_range(32'h0003_0000, 1);
    if ($urandom_range(3) == 0) begin
      c.d11 = rand_word(); c.d12 = rand_word(); c.d21 = rand_word(); c.d22 = rand_word();
    end else begin
      c.d11 = e + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      c.d12 = e + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      c.d21 = e + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      c.d22 = e + $urandom_range(32'h0004_0000) - 32'h0002_0000;
    end
    c.i = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
    c.j = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
    return c;
  endfunction

  function automatic cell_t mk(logic [31:0] d11, d12, d21, d22, p, q,
                               logic [15:0] i, j);
    cell_t c;
    c.d11 = d11; c.d12 = d12; c.d21 = d21; c.d22 = d22;
    c.p = p; c.q = q; c.i = i; c.j = j;
    return c;
  endfunction

  initial begin
    logic [31:0] eps_list[5];
    cell_t dir[$];
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.dist_a1_b1 = '0;
    in_ch.dist_a1_b2 = '0;
    in_ch.dist_a2_b1 = '0;
    in_ch.dist_a2_b2 = '0;
    in_ch.edge_cost_a = 32'd1;
    in_ch.edge_cost_b = 32'd1;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    eps_list = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_0000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default epsilon, then a mid value
    dir.push_back(mk(0, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0));
    dir.push_back(mk('1, '1, '1, '1, '1, '1, '1, '1));
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 16'h1234, 16'h4321));           // zero cost
    dir.push_back(mk('1, 0, 0, '1, 0, '1, 0, '1));
    dir.push_back(mk(0, '1, '1, 0, '1, 0, '1, 0));
    foreach (dir[k]) send_cell(dir[k]);
    drain();
    write_eps(32'h0001_0000);
    dir = {};
    dir.push_back(mk(32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h1_0000, 32'h1_0000, 3, 5));
    dir.push_back(mk(0, 0, 0, 0, 32'h1_0000, 32'h1_0000, 1, 1));
    dir.push_back(mk(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                     32'h1_0000, 2, 2));
    dir.push_back(mk(32'h4000, 32'hC000, 32'h2000, 32'hE000, 32'h2_0000, 32'h8000,
                     16'hFFFF, 16'hFFFF));
    dir.push_back(mk(32'h1_0000, 0, 0, 32'h1_0000, 1, 1, 7, 9));
    dir.push_back(mk(32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h1_0000,
                     32'h1_0000, 0, 0));
    foreach (dir[k]) send_cell(dir[k]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 16 : 0;
      for (int s = 0; s < 5; s++) begin
        write_eps(eps_list[(s + ph) % 5]);
        for (int n = 0; n < 17; n++) begin
          send_cell(rand_cell(sb.eps));
          // hold the sender until the pipeline has emptied
          if (n == 8) begin
            in_ch.valid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clk);
          end
        end
        drain();
      end
    end

    $display("covered %0d cells, %0d side results over five epsilon settings",
             sb.cells, sb.checked);
    $display("stall mixes: sender-heavy, receiver-heavy and none");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
rtl/core/ffsc_pkg.sv
rtl/core/ffsc_in_if.sv
rtl/core/ffsc_out_if.sv
rtl/core/ffsc_cfg_if.sv
rtl/core/frechet_free_space_cell_unit.sv
tb/sv/tb_frechet_free_space_cell_unit.sv
